>>> sv/clipped_alpha_blit_unit_defines.svh
// Assertion macros for the clipped alpha blit unit.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef CLIPPED_ALPHA_BLIT_UNIT_DEFINES_SVH
`define CLIPPED_ALPHA_BLIT_UNIT_DEFINES_SVH

// same-cycle implication
`define CAB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/cab_pkg.sv
// Package for the clipped alpha blit unit: widths, codes and shared types.
// No dependencies; used by the interfaces and all modules.
package cab_pkg;

	localparam int MaxSide   = 4096;
	localparam int SIDE_W    = 13;
	localparam int POS_W     = 13;
	localparam int SIZE_W    = 14;
	localparam int CLIP_W    = 16;
	localparam int COORD_W   = 12;
	localparam int CNT_W     = 12;
	localparam int ADDR_W    = 24;
	localparam int PIX_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_WIDTH    = 3'd0,
		REG_DEST_HEIGHT   = 3'd1,
		REG_SOURCE_WIDTH  = 3'd2,
		REG_SOURCE_HEIGHT = 3'd3,
		REG_BLEND_MODE    = 3'd4
	} reg_idx_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_GEOM  = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	typedef enum logic {
		MODE_SRC_ALPHA = 1'b0,
		MODE_DST_ALPHA = 1'b1
	} mode_t;

	typedef struct packed {
		logic [SIDE_W-1:0] dest_width;
		logic [SIDE_W-1:0] dest_height;
		logic [SIDE_W-1:0] source_width;
		logic [SIDE_W-1:0] source_height;
		logic              blend_mode;
	} cfg_t;

	typedef struct packed {
		logic               kind;
		logic               empty;
		logic [COORD_W-1:0] dx;
		logic [COORD_W-1:0] dy;
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [SIDE_W-1:0]  cols;
		logic [SIDE_W-1:0]  rows;
		logic [PIX_W-1:0]   pixel;
		logic               row_end;
		logic               blit_end;
	} stage_t;

endpackage

>>> sv/cab_if.sv
// Channel interfaces of the clipped alpha blit unit: command, result, register write.
// Depends on cab_pkg.
interface cab_in_if;
	import cab_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic signed [POS_W-1:0]  dest_pos_x;
	logic signed [POS_W-1:0]  dest_pos_y;
	logic signed [POS_W-1:0]  source_pos_x;
	logic signed [POS_W-1:0]  source_pos_y;
	logic signed [SIZE_W-1:0] move_cols;
	logic signed [SIZE_W-1:0] move_rows;
	logic [PIX_W-1:0]         dest_pixel;
	logic [PIX_W-1:0]         source_pixel;

	modport source (output valid, command, dest_pos_x, dest_pos_y, source_pos_x,
		source_pos_y, move_cols, move_rows, dest_pixel, source_pixel, input ready);
	modport sink (input valid, command, dest_pos_x, dest_pos_y, source_pos_x,
		source_pos_y, move_cols, move_rows, dest_pixel, source_pixel, output ready);
endinterface

interface cab_out_if;
	import cab_pkg::*;
	logic              valid;
	logic              ready;
	logic              result_kind;
	logic [ADDR_W-1:0] dest_start_addr;
	logic [ADDR_W-1:0] source_start_addr;
	logic [SIDE_W-1:0] clipped_cols;
	logic [SIDE_W-1:0] clipped_rows;
	logic              nothing_to_move;
	logic [PIX_W-1:0]  blended_pixel;
	logic              row_end;
	logic              blit_end;

	modport source (output valid, result_kind, dest_start_addr, source_start_addr,
		clipped_cols, clipped_rows, nothing_to_move, blended_pixel, row_end, blit_end,
		input ready);
	modport sink (input valid, result_kind, dest_start_addr, source_start_addr,
		clipped_cols, clipped_rows, nothing_to_move, blended_pixel, row_end, blit_end,
		output ready);
endinterface

interface cab_cfg_if;
	import cab_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> sv/clipped_alpha_blit_unit.sv
// Clipped alpha blit unit top level: register port, clip and blend stages, result stage.
// Depends on cab_pkg, cab_if, cab_cfg_regs, cab_seq and cab_addr.
//
// Usage: write bitmap sizes and blend mode on cfg while idle. Send a start
// transaction (command 0) on cmd with positions and move size; one geometry
// answer returns on res with clipped start addresses and size, or
// nothing_to_move. Then send clipped_cols*clipped_rows pixel transactions
// (command 1) in row order; each returns one blended pixel with row_end and
// blit_end marks. Pixel transactions while no blit runs return nothing; a
// start abandons a running blit.
// A result passes the input, clip/blend and result registers before it reaches res.
// Throughput: one transaction per cycle unless res stalls; the address multiply sits
// alone in the last stage and the blend multiplies in the middle one.
// Reset: sizes go to 4096, blend mode to source alpha, the blit to idle and
// the pipeline empties. When res stalls, the result register holds, empty
// stages still fill, and cmd.ready drops once all three stages are full.
module clipped_alpha_blit_unit (
	input  logic      clk,
	input  logic      arst_n,
	cab_in_if.sink    cmd,
	cab_out_if.source res,
	cab_cfg_if.sink   cfg
);
	import cab_pkg::*;

	cfg_t   regs;
	stage_t s2;
	logic   s2_valid;
	logic   s2_ready;

	cab_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	cab_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.regs       (regs),
		.down_ready (s2_ready),
		.s2_valid   (s2_valid),
		.s2         (s2)
	);

	cab_addr u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (s2_valid),
		.s2       (s2),
		.regs     (regs),
		.s2_ready (s2_ready),
		.res      (res)
	);
endmodule

>>> sv/cab_cfg_regs.sv
// Configuration registers: bitmap sizes (saturated to the maximum side) and blend mode.
// Depends on cab_pkg and cab_if.
module cab_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	cab_cfg_if.sink       cfg,
	output cab_pkg::cfg_t regs
);
	import cab_pkg::*;

	cfg_t              regs_q;
	logic [SIDE_W-1:0] side;

	assign cfg.ready = 1'b1;
	assign side = (cfg.data > CFG_DAT_W'(MaxSide)) ? SIDE_W'(MaxSide) : cfg.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.dest_width    <= SIDE_W'(MaxSide);
			regs_q.dest_height   <= SIDE_W'(MaxSide);
			regs_q.source_width  <= SIDE_W'(MaxSide);
			regs_q.source_height <= SIDE_W'(MaxSide);
			regs_q.blend_mode    <= MODE_SRC_ALPHA;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_DEST_WIDTH:    regs_q.dest_width    <= side;
				REG_DEST_HEIGHT:   regs_q.dest_height   <= side;
				REG_SOURCE_WIDTH:  regs_q.source_width  <= side;
				REG_SOURCE_HEIGHT: regs_q.source_height <= side;
				REG_BLEND_MODE:    regs_q.blend_mode    <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;
endmodule

>>> sv/cab_seq.sv
// Input register, clipping, blit sequencing state and pixel blend (stages 1 and 2).
// Depends on cab_pkg, cab_if and the assertion macro header.
`include "clipped_alpha_blit_unit_defines.svh"

module cab_seq (
	input  logic            clk,
	input  logic            arst_n,
	cab_in_if.sink          cmd,
	input  cab_pkg::cfg_t   regs,
	input  logic            down_ready,
	output logic            s2_valid,
	output cab_pkg::stage_t s2
);
	import cab_pkg::*;

	function automatic logic [7:0] mix(input logic [7:0] back, input logic [7:0] front,
		input logic [7:0] alpha);
		logic [15:0] x;
		logic [16:0] t;
		x = 16'(back) * 16'(8'hFF - alpha) + 16'(front) * 16'(alpha);
		// exact x/255 for x up to 255*255
		t = 17'(x) + 17'd1 + 17'(x[15:8]);
		return t[15:8];
	endfunction

	function automatic logic [PIX_W-1:0] blend(input logic [PIX_W-1:0] dst,
		input logic [PIX_W-1:0] src, input logic mode);
		logic [PIX_W-1:0] back;
		logic [PIX_W-1:0] front;
		logic [7:0]       alpha;
		logic [7:0]       out_a;
		if (mode == MODE_DST_ALPHA) begin
			back  = src;
			front = dst;
			alpha = dst[31:24];
			out_a = 8'hFF;
		end else begin
			back  = dst;
			front = src;
			alpha = src[31:24];
			out_a = dst[31:24];
		end
		return {out_a, mix(back[23:16], front[23:16], alpha),
			mix(back[15:8], front[15:8], alpha), mix(back[7:0], front[7:0], alpha)};
	endfunction

	// stage 1 input register
	logic                     v_s1;
	logic                     cmd_s1;
	logic signed [POS_W-1:0]  dx_s1, dy_s1, sx_s1, sy_s1;
	logic signed [SIZE_W-1:0] cols_s1, rows_s1;
	logic [PIX_W-1:0]         dpix_s1, spix_s1;

	// blit state
	logic              active_q;
	logic [SIDE_W-1:0] run_cols_q, run_rows_q;
	logic [CNT_W-1:0]  col_cnt_q, row_cnt_q;

	logic s2_ready, s1_ready, acc, adv, is_start, is_pixel;

	logic signed [CLIP_W-1:0] dxe, dye, sxe, sye, dwe, dhe, swe, she, c0, r0;
	logic signed [CLIP_W-1:0] c1, c2, r1, r2, ndx, nsx, ndy, nsy, mx, my, ex, ey;
	logic signed [CLIP_W-1:0] cols, rows, dxc, dyc, sxc, syc;
	logic                     clip_empty, col_last, row_last;

	stage_t s2_q;
	logic   s2_valid_q;

	assign s2_ready  = !s2_valid_q || down_ready;
	assign s1_ready  = !v_s1 || s2_ready;
	assign cmd.ready = s1_ready;
	assign acc       = cmd.valid && s1_ready;
	assign adv       = v_s1 && s2_ready;
	assign is_start  = (cmd_s1 == CMD_START);
	assign is_pixel  = (cmd_s1 == CMD_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= cmd.command;
			dx_s1   <= cmd.dest_pos_x;
			dy_s1   <= cmd.dest_pos_y;
			sx_s1   <= cmd.source_pos_x;
			sy_s1   <= cmd.source_pos_y;
			cols_s1 <= cmd.move_cols;
			rows_s1 <= cmd.move_rows;
			dpix_s1 <= cmd.dest_pixel;
			spix_s1 <= cmd.source_pixel;
		end
	end

	// clipping
	always_comb begin
		dxe = {{(CLIP_W-POS_W){dx_s1[POS_W-1]}}, dx_s1};
		dye = {{(CLIP_W-POS_W){dy_s1[POS_W-1]}}, dy_s1};
		sxe = {{(CLIP_W-POS_W){sx_s1[POS_W-1]}}, sx_s1};
		sye = {{(CLIP_W-POS_W){sy_s1[POS_W-1]}}, sy_s1};
		c0  = {{(CLIP_W-SIZE_W){cols_s1[SIZE_W-1]}}, cols_s1};
		r0  = {{(CLIP_W-SIZE_W){rows_s1[SIZE_W-1]}}, rows_s1};
		dwe = {{(CLIP_W-SIDE_W){1'b0}}, regs.dest_width};
		dhe = {{(CLIP_W-SIDE_W){1'b0}}, regs.dest_height};
		swe = {{(CLIP_W-SIDE_W){1'b0}}, regs.source_width};
		she = {{(CLIP_W-SIDE_W){1'b0}}, regs.source_height};

		c1 = (c0 < dwe - dxe) ? c0 : dwe - dxe;
		c2 = (c1 < swe - sxe) ? c1 : swe - sxe;
		r1 = (r0 < dhe - dye) ? r0 : dhe - dye;
		r2 = (r1 < she - sye) ? r1 : she - sye;

		ndx = -dxe;
		nsx = -sxe;
		ndy = -dye;
		nsy = -sye;
		mx  = (ndx > nsx) ? ndx : nsx;
		my  = (ndy > nsy) ? ndy : nsy;
		ex  = (mx > 0) ? mx : '0;
		ey  = (my > 0) ? my : '0;

		cols = c2 - ex;
		rows = r2 - ey;
		dxc  = dxe + ex;
		sxc  = sxe + ex;
		dyc  = dye + ey;
		syc  = sye + ey;

		clip_empty = (cols <= 0) || (rows <= 0);
	end

	assign col_last = ({1'b0, col_cnt_q} + SIDE_W'(1)) >= run_cols_q;
	assign row_last = ({1'b0, row_cnt_q} + SIDE_W'(1)) >= run_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			run_cols_q <= '0;
			run_rows_q <= '0;
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
		end else if (adv) begin
			if (is_start) begin
				active_q   <= !clip_empty;
				run_cols_q <= clip_empty ? '0 : cols[SIDE_W-1:0];
				run_rows_q <= clip_empty ? '0 : rows[SIDE_W-1:0];
				col_cnt_q  <= '0;
				row_cnt_q  <= '0;
			end else if (active_q) begin
				if (col_last) begin
					col_cnt_q <= '0;
					if (row_last) begin
						row_cnt_q <= '0;
						active_q  <= 1'b0;
					end else begin
						row_cnt_q <= row_cnt_q + CNT_W'(1);
					end
				end else begin
					col_cnt_q <= col_cnt_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_ready) begin
			s2_valid_q <= v_s1 && (is_start || active_q);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s2_q.kind     <= is_pixel ? KIND_PIXEL : KIND_GEOM;
			s2_q.empty    <= clip_empty;
			s2_q.dx       <= dxc[COORD_W-1:0];
			s2_q.dy       <= dyc[COORD_W-1:0];
			s2_q.sx       <= sxc[COORD_W-1:0];
			s2_q.sy       <= syc[COORD_W-1:0];
			s2_q.cols     <= clip_empty ? '0 : cols[SIDE_W-1:0];
			s2_q.rows     <= clip_empty ? '0 : rows[SIDE_W-1:0];
			s2_q.pixel    <= blend(dpix_s1, spix_s1, regs.blend_mode);
			s2_q.row_end  <= col_last;
			s2_q.blit_end <= col_last && row_last;
		end
	end

	assign s2_valid = s2_valid_q;
	assign s2       = s2_q;

	`CAB_ASSERT_NOW(a_run_nonzero, clk, arst_n, active_q, run_cols_q != 0 && run_rows_q != 0, "active blit with empty run")
	`CAB_ASSERT_NOW(a_cnt_bound, clk, arst_n, active_q, col_cnt_q < run_cols_q && row_cnt_q < run_rows_q, "counter beyond run")
	`CAB_ASSERT_NEXT(a_idle_drop, clk, arst_n, adv && is_pixel && !active_q, !s2_valid_q, "pixel while idle produced a result")
	`CAB_ASSERT_NEXT(a_start_active, clk, arst_n, adv && is_start, active_q == !$past(clip_empty), "start did not set activity from clip")
	`CAB_ASSERT_NOW(a_blit_end, clk, arst_n, s2_valid_q && s2_q.blit_end && s2_q.kind == KIND_PIXEL, s2_q.row_end, "blit end without row end")
endmodule

>>> sv/cab_addr.sv
// Start address computation and result register (stage 3).
// Depends on cab_pkg and cab_if.
module cab_addr (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s2_valid,
	input  cab_pkg::stage_t s2,
	input  cab_pkg::cfg_t   regs,
	output logic            s2_ready,
	cab_out_if.source       res
);
	import cab_pkg::*;

	localparam int PROD_W = ADDR_W + 1;

	logic [PROD_W-1:0] dsum, ssum;
	logic              res_valid_q;
	logic              kind_q, ntm_q, row_end_q, blit_end_q;
	logic [ADDR_W-1:0] daddr_q, saddr_q;
	logic [SIDE_W-1:0] cols_q, rows_q;
	logic [PIX_W-1:0]  pixel_q;
	logic              geom_ok;

	assign dsum = PROD_W'(s2.dy) * PROD_W'(regs.dest_width) + PROD_W'(s2.dx);
	assign ssum = PROD_W'(s2.sy) * PROD_W'(regs.source_width) + PROD_W'(s2.sx);
	assign geom_ok = (s2.kind == KIND_GEOM) && !s2.empty;

	assign s2_ready = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s2_ready) begin
			res_valid_q <= s2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && s2_valid) begin
			kind_q     <= s2.kind;
			ntm_q      <= (s2.kind == KIND_GEOM) && s2.empty;
			daddr_q    <= geom_ok ? dsum[ADDR_W-1:0] : '0;
			saddr_q    <= geom_ok ? ssum[ADDR_W-1:0] : '0;
			cols_q     <= geom_ok ? s2.cols : '0;
			rows_q     <= geom_ok ? s2.rows : '0;
			pixel_q    <= (s2.kind == KIND_PIXEL) ? s2.pixel : '0;
			row_end_q  <= (s2.kind == KIND_PIXEL) && s2.row_end;
			blit_end_q <= (s2.kind == KIND_PIXEL) && s2.blit_end;
		end
	end

	assign res.valid             = res_valid_q;
	assign res.result_kind       = kind_q;
	assign res.dest_start_addr   = daddr_q;
	assign res.source_start_addr = saddr_q;
	assign res.clipped_cols      = cols_q;
	assign res.clipped_rows      = rows_q;
	assign res.nothing_to_move   = ntm_q;
	assign res.blended_pixel     = pixel_q;
	assign res.row_end           = row_end_q;
	assign res.blit_end          = blit_end_q;
endmodule

>>> verif/cab_blit_checker.sv
// Checker for the clipped alpha blit unit: watches cmd, res and cfg, predicts results, compares.
// Depends on cab_pkg and the channel interfaces in cab_if.
module cab_blit_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	cab_in_if                          cmd_mon,
	cab_out_if                         res_mon,
	cab_cfg_if                         cfg_mon,
	output int                         fail_count,
	output int                         outstanding,
	output logic                       blit_live,
	output logic [cab_pkg::SIDE_W-1:0] live_cols,
	output logic [cab_pkg::SIDE_W-1:0] live_rows,
	output int                         geom_seen,
	output int                         empty_seen,
	output int                         pixel_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import cab_pkg::*;

	localparam int ShownFailures = 60;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] daddr;
		logic [ADDR_W-1:0] saddr;
		logic [SIDE_W-1:0] cols;
		logic [SIDE_W-1:0] rows;
		logic              empty;
		logic [PIX_W-1:0]  pixel;
		logic              row_end;
		logic              blit_end;
	} blit_result_t;

	blit_result_t pending_outputs[$];

	logic [SIDE_W-1:0] dest_w, dest_h, src_w, src_h;
	mode_t             mode;
	int unsigned       col_pos, row_pos;

	function automatic logic [SIDE_W-1:0] side_limit(input logic [CFG_DAT_W-1:0] v);
		return (v > MaxSide) ? SIDE_W'(MaxSide) : SIDE_W'(v);
	endfunction

	function automatic blit_result_t clip_move(input logic signed [POS_W-1:0] dxi, dyi, sxi, syi,
			input logic signed [SIZE_W-1:0] ci, ri);
		longint dx, dy, sx, sy, c, r, ex, ey;
		blit_result_t g;
		dx = longint'(dxi);
		dy = longint'(dyi);
		sx = longint'(sxi);
		sy = longint'(syi);
		c = longint'(ci);
		r = longint'(ri);
		if (longint'(dest_w) - dx < c) c = longint'(dest_w) - dx;
		if (longint'(src_w) - sx < c) c = longint'(src_w) - sx;
		ex = 0;
		if (-dx > ex) ex = -dx;
		if (-sx > ex) ex = -sx;
		c -= ex;
		dx += ex;
		sx += ex;
		if (longint'(dest_h) - dy < r) r = longint'(dest_h) - dy;
		if (longint'(src_h) - sy < r) r = longint'(src_h) - sy;
		ey = 0;
		if (-dy > ey) ey = -dy;
		if (-sy > ey) ey = -sy;
		r -= ey;
		dy += ey;
		sy += ey;
		g = '0;
		g.kind = KIND_GEOM;
		if (c <= 0 || r <= 0) begin
			g.empty = 1'b1;
		end else begin
			g.daddr = ADDR_W'(dy * longint'(dest_w) + dx);
			g.saddr = ADDR_W'(sy * longint'(src_w) + sx);
			g.cols = SIDE_W'(c);
			g.rows = SIDE_W'(r);
		end
		return g;
	endfunction

	function automatic logic [PIX_W-1:0] blend_pair(input logic [PIX_W-1:0] dpx, spx,
			input mode_t m);
		logic [PIX_W-1:0] back, front, mixed;
		int unsigned      a, ch_v;
		int               ch;
		if (m == MODE_DST_ALPHA) begin
			back = spx;
			front = dpx;
			a = 32'(dpx[31:24]);
			mixed[31:24] = 8'hFF;
		end else begin
			back = dpx;
			front = spx;
			a = 32'(spx[31:24]);
			mixed[31:24] = dpx[31:24];
		end
		for (ch = 0; ch < 3; ch++) begin
			ch_v = (int'(back[ch*8 +: 8]) * (255 - a) + int'(front[ch*8 +: 8]) * a) / 255;
			mixed[ch*8 +: 8] = ch_v[7:0];
		end
		return mixed;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want, got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= ShownFailures)
				$display("t=%0t %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		blit_result_t want, got;
		if (!arst_n) begin
			pending_outputs.delete();
			dest_w = SIDE_W'(MaxSide);
			dest_h = SIDE_W'(MaxSide);
			src_w = SIDE_W'(MaxSide);
			src_h = SIDE_W'(MaxSide);
			mode = MODE_SRC_ALPHA;
			col_pos = 0;
			row_pos = 0;
			blit_live = 1'b0;
			live_cols = '0;
			live_rows = '0;
			outstanding = 0;
		end else begin
			if (res_mon.valid && res_mon.ready) begin
				got.kind = kind_t'(res_mon.result_kind);
				got.daddr = res_mon.dest_start_addr;
				got.saddr = res_mon.source_start_addr;
				got.cols = res_mon.clipped_cols;
				got.rows = res_mon.clipped_rows;
				got.empty = res_mon.nothing_to_move;
				got.pixel = res_mon.blended_pixel;
				got.row_end = res_mon.row_end;
				got.blit_end = res_mon.blit_end;
				if (pending_outputs.size() == 0) begin
					fail_count++;
					if (fail_count <= ShownFailures)
						$display("t=%0t result with none pending: expected nothing, actual 0x%0h",
							$time, got);
				end else begin
					want = pending_outputs.pop_front();
					check_field("result_kind", want.kind, got.kind);
					check_field("dest_start_addr", want.daddr, got.daddr);
					check_field("source_start_addr", want.saddr, got.saddr);
					check_field("clipped_cols", want.cols, got.cols);
					check_field("clipped_rows", want.rows, got.rows);
					check_field("nothing_to_move", want.empty, got.empty);
					check_field("blended_pixel", want.pixel, got.pixel);
					check_field("row_end", want.row_end, got.row_end);
					check_field("blit_end", want.blit_end, got.blit_end);
					if (want.kind == KIND_PIXEL) begin
						pixel_seen++;
					end else begin
						geom_seen++;
						if (want.empty)
							empty_seen++;
					end
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) begin
				case (reg_idx_t'(cfg_mon.index))
					REG_DEST_WIDTH:    dest_w = side_limit(cfg_mon.data);
					REG_DEST_HEIGHT:   dest_h = side_limit(cfg_mon.data);
					REG_SOURCE_WIDTH:  src_w = side_limit(cfg_mon.data);
					REG_SOURCE_HEIGHT: src_h = side_limit(cfg_mon.data);
					REG_BLEND_MODE:    mode = mode_t'(cfg_mon.data[0]);
					default: ;
				endcase
			end
			if (cmd_mon.valid && cmd_mon.ready) begin
				if (cmd_t'(cmd_mon.command) == CMD_START) begin
					want = clip_move(cmd_mon.dest_pos_x, cmd_mon.dest_pos_y, cmd_mon.source_pos_x,
						cmd_mon.source_pos_y, cmd_mon.move_cols, cmd_mon.move_rows);
					col_pos = 0;
					row_pos = 0;
					blit_live = !want.empty;
					live_cols = want.cols;
					live_rows = want.rows;
					pending_outputs.push_back(want);
				end else if (blit_live) begin
					want = '0;
					want.kind = KIND_PIXEL;
					want.pixel = blend_pair(cmd_mon.dest_pixel, cmd_mon.source_pixel, mode);
					if (col_pos + 1 >= live_cols) begin
						want.row_end = 1'b1;
						col_pos = 0;
						if (row_pos + 1 >= live_rows) begin
							want.blit_end = 1'b1;
							row_pos = 0;
							blit_live = 1'b0;
						end else begin
							row_pos++;
						end
					end else begin
						col_pos++;
					end
					pending_outputs.push_back(want);
				end
			end
			outstanding = pending_outputs.size();
		end
	end

endmodule

>>> verif/tb_clipped_alpha_blit_unit.sv
// Testbench top for the clipped alpha blit unit: clock, reset, stimulus and verdict.
// Depends on cab_pkg, cab_if, clipped_alpha_blit_unit and cab_blit_checker.
module tb_clipped_alpha_blit_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import cab_pkg::*;

	localparam int HalfPeriod  = 6;
	localparam int RandomItems = 1450;
	localparam int HoldCycles  = 200;

	logic clk = 1'b0;
	logic arst_n;

	cab_in_if  cmd_ch();
	cab_out_if res_ch();
	cab_cfg_if cfg_ch();

	int                fail_count, outstanding, geom_seen, empty_seen, pixel_seen;
	logic              blit_live;
	logic [SIDE_W-1:0] live_cols, live_rows;

	int random_items, settings_used, pixels_left;
	int dw_side, dh_side, sw_side, sh_side;
	bit sender_steady, recv_steady, hold_results;

	clipped_alpha_blit_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	cab_blit_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_mon     (cmd_ch),
		.res_mon     (res_ch),
		.cfg_mon     (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.blit_live   (blit_live),
		.live_cols   (live_cols),
		.live_rows   (live_rows),
		.geom_seen   (geom_seen),
		.empty_seen  (empty_seen),
		.pixel_seen  (pixel_seen)
	);

	always begin
		#(HalfPeriod) clk = 1'b1;
		#(HalfPeriod) clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("run did not finish in time");
		$display("** clipped_alpha_blit_unit: FAILED **");
		$finish;
	end

	// result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int  wait_n;
		bit  hold;
		bit  held_once;
		res_ch.ready = 1'b0;
		held_once = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			hold = hold_results && !held_once;
			wait_n = recv_steady ? 0 : $urandom_range(0, 6);
			@(negedge clk);
			if (hold) begin
				res_ch.ready = 1'b0;
				repeat (HoldCycles) @(negedge clk);
				held_once = 1'b1;
			end else if (wait_n > 0) begin
				res_ch.ready = 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// entered and left at a falling edge
	task automatic offer(input cmd_t op, input logic signed [POS_W-1:0] dx, dy, sx, sy,
			input logic signed [SIZE_W-1:0] mc, mr, input logic [PIX_W-1:0] dpx, spx);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.command = op;
		cmd_ch.dest_pos_x = dx;
		cmd_ch.dest_pos_y = dy;
		cmd_ch.source_pos_x = sx;
		cmd_ch.source_pos_y = sy;
		cmd_ch.move_cols = mc;
		cmd_ch.move_rows = mr;
		cmd_ch.dest_pixel = dpx;
		cmd_ch.source_pixel = spx;
		cmd_ch.valid = 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	function automatic int rand_move_full();
		return int'($urandom_range(0, 8192)) - 4096;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] p;
		p = $urandom;
		case ($urandom_range(0, 7))
			0: p[31:24] = 8'h00;
			1: p[31:24] = 8'hFF;
			default: ;
		endcase
		return p;
	endfunction

	task automatic start_blit(input int dx, dy, sx, sy, mc, mr);
		offer(CMD_START, POS_W'(dx), POS_W'(dy), POS_W'(sx), POS_W'(sy), SIZE_W'(mc),
			SIZE_W'(mr), $urandom, $urandom);
		pixels_left = blit_live ? int'(live_cols) * int'(live_rows) : 0;
		random_items++;
	endtask

	task automatic feed_pixel(input logic [PIX_W-1:0] dpx, spx);
		offer(CMD_PIXEL, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
			POS_W'($urandom), SIZE_W'(rand_move_full()), SIZE_W'(rand_move_full()), dpx, spx);
		if (pixels_left > 0) begin
			pixels_left--;
			random_items++;
		end
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] value);
		cfg_ch.index = idx;
		cfg_ch.data = value;
		cfg_ch.valid = 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
	endtask

	task automatic settle();
		cmd_ch.valid = 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic configure(input int dw, dh, sw, sh, input logic [CFG_DAT_W-1:0] mode_data);
		settle();
		write_reg(REG_DEST_WIDTH, CFG_DAT_W'(dw));
		write_reg(REG_DEST_HEIGHT, CFG_DAT_W'(dh));
		write_reg(REG_SOURCE_WIDTH, CFG_DAT_W'(sw));
		write_reg(REG_SOURCE_HEIGHT, CFG_DAT_W'(sh));
		write_reg(REG_BLEND_MODE, mode_data);
		cfg_ch.valid = 1'b0;
		dw_side = (dw > MaxSide) ? MaxSide : dw;
		dh_side = (dh > MaxSide) ? MaxSide : dh;
		sw_side = (sw > MaxSide) ? MaxSide : sw;
		sh_side = (sh > MaxSide) ? MaxSide : sh;
		settings_used++;
	endtask

	function automatic int pick_side();
		case ($urandom_range(0, 11))
			0: return 1;
			1: return MaxSide;
			2: return $urandom_range(0, 8191);
			3: return $urandom_range(13, 64);
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	function automatic int pick_pos(input int side);
		int p;
		case ($urandom_range(0, 3))
			0: p = -int'($urandom_range(0, 4));
			1: p = side - int'($urandom_range(0, 6));
			default: p = (side > 1) ? int'($urandom_range(0, side - 1)) : 0;
		endcase
		if (p > 4095)
			p = 4095;
		return p;
	endfunction

	function automatic int pick_move();
		case ($urandom_range(0, 15))
			0: return 0;
			1: return -int'($urandom_range(1, 4096));
			2: return 4096;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	// mostly complete blits; some abandoned, some noise geometry, some stray pixels
	task automatic run_blit();
		int n_send;
		sender_steady = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 6) == 0)
			start_blit($urandom, $urandom, $urandom, $urandom, rand_move_full(), rand_move_full());
		else
			start_blit(pick_pos(dw_side), pick_pos(dh_side), pick_pos(sw_side), pick_pos(sh_side),
				pick_move(), pick_move());
		n_send = pixels_left;
		if (n_send > 300 || $urandom_range(0, 9) == 0)
			n_send = $urandom_range(0, (n_send < 40) ? n_send : 40);
		repeat (n_send) feed_pixel(rand_pixel(), rand_pixel());
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) feed_pixel(rand_pixel(), rand_pixel());
	endtask

	initial begin : stimulus
		int phase, phase_end, drain_cycles;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.command = CMD_START;
		cmd_ch.dest_pos_x = '0;
		cmd_ch.dest_pos_y = '0;
		cmd_ch.source_pos_x = '0;
		cmd_ch.source_pos_y = '0;
		cmd_ch.move_cols = '0;
		cmd_ch.move_rows = '0;
		cmd_ch.dest_pixel = '0;
		cmd_ch.source_pixel = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DEST_WIDTH;
		cfg_ch.data = '0;
		sender_steady = 1'b0;
		recv_steady = 1'b0;
		hold_results = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed
		configure(8, 6, 5, 7, 13'd0);
		feed_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		start_blit(1, 2, 0, 1, 3, 2);
		feed_pixel(32'h00000000, 32'h00000000);
		feed_pixel(32'hFFFFFFFF, 32'hFFFFFFFF);
		feed_pixel(32'hFFFFFFFF, 32'h00000000);
		feed_pixel(32'h00000000, 32'hFFFFFFFF);
		feed_pixel(32'h12345678, 32'h80A0C0E0);
		feed_pixel(rand_pixel(), rand_pixel());
		start_blit(-1, 0, -3, 0, 6, 1);
		feed_pixel(rand_pixel(), rand_pixel());
		start_blit(4095, 4095, -4096, -4096, 4096, 4096);
		start_blit(-4096, -4096, 4095, 4095, -4096, -4096);
		start_blit(0, 0, 0, 0, 0, 5);
		start_blit(6, 5, 3, 6, 5, 5);
		feed_pixel(rand_pixel(), rand_pixel());
		feed_pixel(rand_pixel(), rand_pixel());
		feed_pixel(rand_pixel(), rand_pixel());
		configure(8, 6, 5, 7, 13'd1);
		start_blit(0, 0, 0, 0, 2, 1);
		feed_pixel(32'h00FF8040, 32'hFF102030);
		feed_pixel(32'hFF00FF00, 32'h00FFFFFF);
		configure(8191, 8191, 8191, 8191, 13'h1FFE);
		start_blit(4095, 4095, 4095, 4095, 4096, 4096);
		feed_pixel(rand_pixel(), rand_pixel());
		settle();
		write_reg(REG_DEST_WIDTH, 13'd0);
		cfg_ch.valid = 1'b0;
		start_blit(0, 0, 0, 0, 1, 1);

		// random
		random_items = 0;
		phase = 0;
		while (random_items < RandomItems) begin
			case (phase)
				0: configure(MaxSide, MaxSide, MaxSide, MaxSide, 13'd0);
				1: configure(1, 1, 1, 1, 13'd1);
				2: configure(16, 16, 16, 16, CFG_DAT_W'($urandom_range(0, 8191)));
				default: configure(pick_side(), pick_side(), pick_side(), pick_side(),
					CFG_DAT_W'($urandom_range(0, 8191)));
			endcase
			recv_steady = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// long result stall while the sender keeps streaming
				recv_steady = 1'b0;
				hold_results = 1'b1;
				sender_steady = 1'b1;
				start_blit(0, 0, 0, 0, 12, 8);
				while (pixels_left > 0)
					feed_pixel(rand_pixel(), rand_pixel());
			end
			phase_end = random_items + $urandom_range(80, 200);
			while (random_items < phase_end && random_items < RandomItems)
				run_blit();
			phase++;
		end

		cmd_ch.valid = 1'b0;
		drain_cycles = 0;
		while (outstanding != 0 && drain_cycles < 5000) begin
			@(negedge clk);
			drain_cycles++;
		end
		repeat (8) @(negedge clk);
		$display("covered %0d geometry answers (%0d empty) and %0d blended pixels",
			geom_seen, empty_seen, pixel_seen);
		$display("over %0d register settings, %0d failing checks", settings_used, fail_count);
		if (fail_count == 0 && outstanding == 0) begin
			$display("** clipped_alpha_blit_unit: PASSED **");
		end else begin
			if (outstanding != 0)
				$display("%0d expected results never arrived", outstanding);
			$display("** clipped_alpha_blit_unit: FAILED **");
		end
		$finish;
	end

endmodule
